// File: rtl/core/kwm_pkg.sv
package kwm_pkg;

	// Sizing
	localparam int LISTS  = 8;
	localparam int DEPTH  = 64;
	localparam int WORDS  = LISTS * DEPTH;
	localparam int IDX_W  = $clog2(LISTS);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(WORDS);
	localparam int DATA_W = 32;

	// Request modes
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_TAKE   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESOLVE,
		S_PUSH
	} state_t;

	// Control into the shared minimum unit
	typedef struct packed {
		logic             start;
		logic             valid;
		logic [IDX_W-1:0] idx;
	} min_ctl_t;

endpackage

// File: rtl/core/kwm_cmd_if.sv
interface kwm_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [2:0]         list_index;
	logic signed [31:0] value;

	modport source (output valid, output mode, output list_index, output value, input ready);
	modport sink (input valid, input mode, input list_index, input value, output ready);
endinterface

// File: rtl/core/kwm_rsp_if.sv
interface kwm_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic               out_valid;
	logic [1:0]         status;

	modport source (output valid, output out_value, output out_valid, output status, input ready);
	modport sink (input valid, input out_value, input out_valid, input status, output ready);
endinterface

// File: rtl/core/kwm_ram.sv
module kwm_ram #(
	parameter int DATA_W = 32,
	parameter int WORDS  = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(WORDS)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(WORDS)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [WORDS];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/kwm_min.sv
module kwm_min (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kwm_pkg::min_ctl_t           ctl,
	input  logic signed [31:0]          data,
	output logic                        found_q,
	output logic [kwm_pkg::IDX_W-1:0]   best_idx_q,
	output logic signed [31:0]          best_val_q
);

	import kwm_pkg::*;

	logic take;

	// Strict less-than keeps the earlier (lower) list on equal heads
	assign take = ctl.valid && (!found_q || (data < best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Running minimum, no reset needed
	always_ff @(posedge clk) begin
		if (!ctl.start && take) begin
			best_val_q <= data;
			best_idx_q <= ctl.idx;
		end
	end

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !found_q)
		else $error("minimum unit not cleared by start");

endmodule

// File: rtl/core/k_way_sorted_list_merge.sv
// Append, clear and unused modes: result registered on acceptance.
// Take: heads are compared one list per cycle on a single comparator fed by the
// list store's read port.
// One request is in flight at a time; ready is low while it is worked on.
// arst_n clears fill counts, read positions and the sequencer; the store is not cleared.
module k_way_sorted_list_merge (
	input logic      clk,
	input logic      arst_n,
	kwm_cmd_if.sink  cmd,
	kwm_rsp_if.source rsp
);

	import kwm_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  fill_q [LISTS];
	logic [CNT_W-1:0]  rpos_q [LISTS];
	logic [IDX_W-1:0]  scan_q;
	logic [ADDR_W-1:0] base_q;
	logic              hit_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              res_valid_q;
	logic signed [31:0] res_val_q;
	logic [1:0]        res_st_q;

	logic              rsp_valid_q;
	logic signed [31:0] rsp_val_q;
	logic              rsp_ov_q;
	logic [1:0]        rsp_st_q;

	logic              accept;
	logic [IDX_W-1:0]  app_idx;
	logic              app_ok;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              hit;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       rd_data;
	logic              last_scan;
	logic              push;

	min_ctl_t          mctl;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic signed [31:0] best_val_q;

	assign accept  = cmd.valid && cmd.ready;
	assign app_idx = IDX_W'(cmd.list_index);
	assign app_ok  = (32'(cmd.list_index) < LISTS) && (fill_q[app_idx] < CNT_W'(DEPTH));
	assign wr_en   = accept && (cmd.mode == MODE_APPEND) && app_ok;
	assign wr_addr = ADDR_W'(32'(app_idx) * DEPTH + 32'(fill_q[app_idx]));

	// Head fetch for the list under scan
	assign hit       = (state_q == S_SCAN) && (rpos_q[scan_q] < fill_q[scan_q]);
	assign rd_addr   = base_q + ADDR_W'(rpos_q[scan_q]);
	assign last_scan = (scan_q == IDX_W'(LISTS - 1));
	assign push      = (state_q == S_PUSH) && (!rsp_valid_q || rsp.ready);

	assign mctl.start = accept && (cmd.mode == MODE_TAKE);
	assign mctl.valid = hit_s1;
	assign mctl.idx   = idx_s1;

	kwm_ram #(
		.DATA_W (DATA_W),
		.WORDS  (WORDS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (hit),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kwm_min u_min (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mctl),
		.data       ($signed(rd_data)),
		.found_q    (found_q),
		.best_idx_q (best_idx_q),
		.best_val_q (best_val_q)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and ready
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = (cmd.mode == MODE_TAKE) ? S_SCAN : S_PUSH;
				end
			end
			S_SCAN: begin
				if (last_scan) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:   state_d = S_RESOLVE;
			S_RESOLVE: state_d = S_PUSH;
			S_PUSH: begin
				if (push) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// List bookkeeping and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				fill_q[i] <= '0;
				rpos_q[i] <= '0;
			end
			scan_q <= '0;
			base_q <= '0;
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= hit;
			if (accept && (cmd.mode == MODE_CLEAR)) begin
				for (int i = 0; i < LISTS; i++) begin
					fill_q[i] <= '0;
					rpos_q[i] <= '0;
				end
			end
			if (wr_en) begin
				fill_q[app_idx] <= fill_q[app_idx] + 1'b1;
			end
			if (mctl.start) begin
				scan_q <= '0;
				base_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + 1'b1;
				base_q <= base_q + ADDR_W'(DEPTH);
			end
			if ((state_q == S_RESOLVE) && found_q) begin
				rpos_q[best_idx_q] <= rpos_q[best_idx_q] + 1'b1;
			end
		end
	end

	// Pipeline tag alongside the store read
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
	end

	// Pending result, formed at acceptance or after the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			res_valid_q <= 1'b0;
			res_val_q   <= '0;
			case (cmd.mode)
				MODE_APPEND: res_st_q <= app_ok ? ST_OK : ST_FULL;
				default:     res_st_q <= ST_OK;
			endcase
		end else if (state_q == S_RESOLVE) begin
			res_valid_q <= found_q;
			res_val_q   <= found_q ? best_val_q : '0;
			res_st_q    <= found_q ? ST_OK : ST_EMPTY;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_val_q <= res_val_q;
			rsp_ov_q  <= res_valid_q;
			rsp_st_q  <= res_st_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_value = rsp_val_q;
	assign rsp.out_valid = rsp_ov_q;
	assign rsp.status    = rsp_st_q;

	a_merged_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_valid |-> (rsp.status == ST_OK))
		else $error("merged element with non-ok status");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> ($past(state_q) == S_SCAN))
		else $error("store read outside scan");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (fill_q[app_idx] < CNT_W'(DEPTH)))
		else $error("append past list depth");

	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESOLVE) && found_q |->
			(rpos_q[best_idx_q] < fill_q[best_idx_q]))
		else $error("advancing a spent list");

endmodule

// File: bench/k_way_sorted_list_merge_tb.sv
module k_way_sorted_list_merge_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kwm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 4 * (LISTS + 4);
	localparam int MAX_REPORTS = 10;
	localparam longint VAL_MAX = 64'sd2147483647;

	typedef struct {
		logic [1:0]               mode;
		logic [2:0]               list_index;
		logic signed [DATA_W-1:0] value;
		bit                       hold;
	} merge_req_t;

	typedef struct {
		logic signed [DATA_W-1:0] out_value;
		logic                     out_valid;
		logic [1:0]               status;
	} merge_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	kwm_cmd_if cmd_if ();
	kwm_rsp_if rsp_if ();

	k_way_sorted_list_merge u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	// Shadow copy of the lists, fill counts and read positions
	logic signed [DATA_W-1:0] list_words [LISTS][DEPTH];
	int unsigned              list_fill  [LISTS];
	int unsigned              list_head  [LISTS];

	merge_req_t pending_q [$];
	merge_rsp_t due_q     [$];
	merge_req_t cur_req;
	bit         cmd_busy;
	int         item_count;
	int         mismatches;
	int         cycle_count;
	int         burst_left = 1;
	int         gap_left;
	int         stall_left;
	int         phase_left;
	bit         choppy;

	// 500 MHz bench clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected result of one request; updates the shadow state
	function automatic merge_rsp_t merge_step(input merge_req_t r);
		merge_rsp_t               res;
		bit                       found;
		int                       best;
		logic signed [DATA_W-1:0] best_val;
		res.out_value = '0;
		res.out_valid = 1'b0;
		res.status    = ST_OK;
		found    = 1'b0;
		best     = 0;
		best_val = '0;
		case (r.mode)
			MODE_APPEND: begin
				if (int'(r.list_index) >= LISTS || list_fill[r.list_index] >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					list_words[r.list_index][list_fill[r.list_index]] = r.value;
					list_fill[r.list_index]++;
				end
			end
			MODE_TAKE: begin
				// lowest index wins on equal heads, hence strict less-than
				for (int i = 0; i < LISTS; i++) begin
					if (list_head[i] < list_fill[i]) begin
						if (!found || list_words[i][list_head[i]] < best_val) begin
							found    = 1'b1;
							best     = i;
							best_val = list_words[i][list_head[i]];
						end
					end
				end
				if (found) begin
					list_head[best]++;
					res.out_value = best_val;
					res.out_valid = 1'b1;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < LISTS; i++) begin
					list_fill[i] = 0;
					list_head[i] = 0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic add_req(input logic [1:0] mode, input int idx,
			input logic signed [DATA_W-1:0] value, input bit hold);
		merge_req_t r;
		r.mode       = mode;
		r.list_index = idx[2:0];
		r.value      = value;
		r.hold       = hold;
		pending_q.push_back(r);
		if (mode != MODE_UNUSED) item_count++;
	endtask

	// Loads a random spread of lists, then drains them with takes
	task automatic add_batch(input bit sorted);
		longint                   nxt  [LISTS];
		int                       left [LISTS];
		int                       total;
		int                       lst;
		bit                       tiny;
		logic signed [DATA_W-1:0] v;
		total = 0;
		// narrow value range makes equal heads likely
		tiny = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < LISTS; i++) begin
			left[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (tiny) nxt[i] = longint'($urandom_range(0, 6)) - 3;
			else if ($urandom_range(0, 9) == 0) nxt[i] = -64'sd2147483648;
			else nxt[i] = longint'($signed($urandom));
			total += left[i];
		end
		for (int n = 0; n < total; n++) begin
			do lst = $urandom_range(0, LISTS - 1); while (left[lst] == 0);
			left[lst]--;
			v = nxt[lst][DATA_W-1:0];
			add_req(MODE_APPEND, lst, sorted ? v : $urandom, 1'b0);
			if (tiny) nxt[lst] += $urandom_range(0, 2);
			else if ($urandom_range(0, 3) == 0) nxt[lst] += $urandom_range(0, 1 << 24);
			else nxt[lst] += $urandom_range(0, 1000);
			if (nxt[lst] > VAL_MAX) nxt[lst] = VAL_MAX;
			if ($urandom_range(0, 9) == 0) add_req(MODE_TAKE, $urandom, $urandom, 1'b0);
			if ($urandom_range(0, 24) == 0) add_req(MODE_UNUSED, $urandom, $urandom, 1'b0);
		end
		for (int n = 0; n < total + $urandom_range(0, 2); n++) begin
			add_req(MODE_TAKE, $urandom, $urandom, 1'b0);
			if ($urandom_range(0, 24) == 0) add_req(MODE_UNUSED, $urandom, $urandom, 1'b0);
		end
	endtask

	// Fills one list past its depth; takes must not free room
	task automatic add_fill_case();
		int     lst;
		longint v;
		lst = $urandom_range(0, LISTS - 1);
		v   = longint'($urandom_range(0, 1000)) - 500;
		add_req(MODE_CLEAR, $urandom, $urandom, 1'b1);
		for (int n = 0; n < DEPTH + 2; n++) begin
			add_req(MODE_APPEND, lst, v[DATA_W-1:0], 1'b0);
			v += $urandom_range(0, 50);
		end
		for (int n = 0; n < 3; n++) add_req(MODE_TAKE, 0, 0, 1'b0);
		add_req(MODE_APPEND, lst, v[DATA_W-1:0], 1'b0);
		add_req(MODE_APPEND, (lst + 1) % LISTS, v[DATA_W-1:0], 1'b0);
		for (int n = 0; n < DEPTH; n++) add_req(MODE_TAKE, $urandom, $urandom, 1'b0);
	endtask

	task automatic add_noise();
		int cnt;
		cnt = $urandom_range(5, 15);
		for (int n = 0; n < cnt; n++) begin
			add_req(2'($urandom_range(0, 3)), $urandom, $urandom, 1'b0);
		end
	endtask

	// Request driver: bursts with random gaps, changes on the falling edge
	always @(negedge clk) begin : drive_cmd
		logic nxt_valid;
		nxt_valid = cmd_if.valid;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!cmd_busy) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() != 0 &&
					!(pending_q[0].hold && due_q.size() != 0)) begin
				cur_req = pending_q.pop_front();
				cmd_if.mode       <= cur_req.mode;
				cmd_if.list_index <= cur_req.list_index;
				cmd_if.value      <= cur_req.value;
				nxt_valid = 1'b1;
				cmd_busy  = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		cmd_if.valid <= nxt_valid;
	end

	// Result ready: free-running phases alternate with choppy ones
	always @(negedge clk) begin : drive_rsp_ready
		logic nxt_ready;
		if (!arst_n) begin
			nxt_ready = 1'b0;
		end else begin
			if (phase_left == 0) begin
				choppy     = ($urandom_range(0, 2) != 0);
				phase_left = $urandom_range(20, 150);
			end else begin
				phase_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else if (choppy && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 20);
				nxt_ready  = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
		end
		rsp_if.ready <= nxt_ready;
	end

	// Monitor: predicts on each accepted request, checks each accepted result
	always @(posedge clk) begin : watch
		merge_rsp_t want;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				due_q.push_back(merge_step(cur_req));
				cmd_busy = 1'b0;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: value %0d valid %0b status %0d",
							rsp_if.out_value, rsp_if.out_valid, rsp_if.status);
				end else begin
					want = due_q.pop_front();
					if (rsp_if.out_value !== want.out_value ||
							rsp_if.out_valid !== want.out_valid ||
							rsp_if.status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: value exp %0d got %0d,",
								want.out_value, rsp_if.out_value,
								" valid exp %0b got %0b,",
								want.out_valid, rsp_if.out_valid,
								" status exp %0d got %0d",
								want.status, rsp_if.status);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int pick;
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.mode       = MODE_APPEND;
		cmd_if.list_index = '0;
		cmd_if.value      = '0;
		rsp_if.ready      = 1'b0;
		for (int i = 0; i < LISTS; i++) begin
			list_fill[i] = 0;
			list_head[i] = 0;
		end

		// Directed: empty take, unused mode, clear, extremes and equal heads
		add_req(MODE_TAKE, 0, 0, 1'b0);
		add_req(MODE_UNUSED, 7, 32'h7fff_ffff, 1'b0);
		add_req(MODE_CLEAR, 7, 32'hffff_ffff, 1'b0);
		add_req(MODE_APPEND, 0, 32'h8000_0000, 1'b0);
		add_req(MODE_APPEND, 7, 32'h7fff_ffff, 1'b0);
		add_req(MODE_APPEND, 3, 32'h0000_0000, 1'b0);
		add_req(MODE_APPEND, 5, 32'hffff_ffff, 1'b0);
		add_req(MODE_APPEND, 1, 32'h0000_0000, 1'b0);
		add_req(MODE_APPEND, 2, 32'h8000_0000, 1'b0);
		add_req(MODE_APPEND, 4, 32'h5555_5555, 1'b0);
		add_req(MODE_APPEND, 6, 32'haaaa_aaaa, 1'b0);
		// wait for the loads to drain before the takes
		add_req(MODE_TAKE, 5, 32'h1234_5678, 1'b1);
		for (int n = 0; n < LISTS; n++) add_req(MODE_TAKE, 0, 0, 1'b0);
		// unsorted list: smallest head still comes first
		add_req(MODE_APPEND, 2, 32'd9, 1'b0);
		add_req(MODE_APPEND, 2, -32'sd4, 1'b0);
		add_req(MODE_APPEND, 6, 32'd3, 1'b0);
		add_req(MODE_TAKE, 0, 0, 1'b0);
		add_req(MODE_CLEAR, 0, 0, 1'b0);
		add_req(MODE_TAKE, 0, 0, 1'b0);

		// Random part: mostly well-formed merges, some overflow and noise
		add_fill_case();
		while (item_count < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				add_fill_case();
			end else if (pick < 3) begin
				add_noise();
			end else begin
				if ($urandom_range(0, 3) != 0)
					add_req(MODE_CLEAR, $urandom, $urandom, $urandom_range(0, 7) == 0);
				add_batch(pick >= 5);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || cmd_busy || due_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
